/* hdl/dvdi_pkg.sv */
package dvdi_pkg;

   localparam int DEPTH_DEF = 1024;
   localparam int TIME_W = 48;
   localparam int SAMPLE_W = 16;
   localparam int MAXD_W = 32;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 32;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_DELAY = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INIT_VALUE = 2'd1;

   localparam logic [MAXD_W-1:0] MAX_DELAY_RST = 32'd1024;
   localparam logic [SAMPLE_W-1:0] INIT_VALUE_RST = 16'd0;

   // interpolation operand widths
   localparam int X_W = TIME_W + 2;
   localparam int DT_W = TIME_W + 1;
   localparam int D_W = SAMPLE_W + 1;
   localparam int QBITS = 18;

   typedef struct packed {
      logic start;
      logic signed [X_W-1:0] x;
      logic signed [D_W-1:0] d;
      logic signed [DT_W-1:0] dt;
      logic signed [SAMPLE_W-1:0] sa;
   } interp_req_type;

   typedef struct packed {
      logic done;
      logic signed [SAMPLE_W-1:0] value;
   } interp_rsp_type;

endpackage

/* hdl/dvdi_ram.sv */
module dvdi_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 1024
) (
   input  logic clock,
   input  logic we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

/* hdl/dvdi_interp.sv */
module dvdi_interp (
   input  logic clock,
   input  logic reset,
   input  dvdi_pkg::interp_req_type req,
   output dvdi_pkg::interp_rsp_type rsp
);

   localparam int XW = dvdi_pkg::X_W;
   localparam int DW = dvdi_pkg::D_W;
   localparam int TW = dvdi_pkg::DT_W;
   localparam int SW = dvdi_pkg::SAMPLE_W;
   localparam int QB = dvdi_pkg::QBITS;
   localparam int LOW_W = 25;
   localparam int HIGH_W = XW - LOW_W;
   localparam int PP_W = LOW_W + DW;
   localparam int PR_W = XW + DW;
   localparam int CW = $clog2(QB + 1);
   localparam int RW = QB + 3;

   typedef enum logic [2:0] {
      I_IDLE, I_MUL0, I_MUL1, I_SUM, I_CHK, I_DIV, I_OUT
   } istate_type;

   istate_type state_ff;
   logic [XW-1:0] ax_ff;
   logic [DW-1:0] ad_ff;
   logic [TW-1:0] adt_ff;
   logic neg_ff, zero_ff, ovf_ff, done_ff;
   logic signed [SW-1:0] sa_ff, value_ff;
   logic [PP_W-1:0] plo_ff, phi_ff;
   logic [PR_W-1:0] prod_ff;
   logic [TW-1:0] rem_ff;
   logic [QB-1:0] low_ff, q_ff;
   logic [CW-1:0] cnt_ff;

   logic [TW:0] rem2;
   logic ge;
   logic [QB:0] qsel;
   logic signed [RW-1:0] r;

   // one restoring division step
   assign rem2 = {rem_ff, low_ff[QB-1]};
   assign ge = rem2 >= {1'b0, adt_ff};

   // signed sum and saturation
   assign qsel = ovf_ff ? {1'b1, {QB{1'b0}}} : {1'b0, q_ff};
   assign r = RW'(sa_ff) + (neg_ff ? -RW'(signed'({1'b0, qsel}))
                                    : RW'(signed'({1'b0, qsel})));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= I_IDLE;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         unique case (state_ff)
            I_IDLE: begin
               if (req.start) begin
                  ax_ff <= req.x[XW-1] ? XW'(-req.x) : XW'(req.x);
                  ad_ff <= req.d[DW-1] ? DW'(-req.d) : DW'(req.d);
                  adt_ff <= req.dt[TW-1] ? TW'(-req.dt) : TW'(req.dt);
                  neg_ff <= (req.x[XW-1] ^ req.d[DW-1]) ^ req.dt[TW-1];
                  zero_ff <= req.dt == '0;
                  sa_ff <= req.sa;
                  state_ff <= I_MUL0;
               end
            end
            I_MUL0: begin
               plo_ff <= PP_W'(ax_ff[LOW_W-1:0] * ad_ff);
               state_ff <= zero_ff ? I_OUT : I_MUL1;
            end
            I_MUL1: begin
               phi_ff <= PP_W'(ax_ff[XW-1:LOW_W] * ad_ff);
               state_ff <= I_SUM;
            end
            I_SUM: begin
               prod_ff <= {phi_ff[PR_W-LOW_W-1:0], {LOW_W{1'b0}}} + PR_W'(plo_ff);
               state_ff <= I_CHK;
            end
            I_CHK: begin
               // quotient at or above 2^QB saturates anyway
               ovf_ff <= prod_ff[PR_W-1:QB] >= adt_ff;
               rem_ff <= prod_ff[PR_W-1:QB];
               low_ff <= prod_ff[QB-1:0];
               q_ff <= '0;
               cnt_ff <= CW'(QB);
               state_ff <= I_DIV;
            end
            I_DIV: begin
               if (ovf_ff || cnt_ff == '0) begin
                  state_ff <= I_OUT;
               end else begin
                  rem_ff <= ge ? TW'(rem2 - {1'b0, adt_ff}) : rem2[TW-1:0];
                  low_ff <= {low_ff[QB-2:0], 1'b0};
                  q_ff <= {q_ff[QB-2:0], ge};
                  cnt_ff <= cnt_ff - 1'b1;
               end
            end
            I_OUT: begin
               if (zero_ff) begin
                  value_ff <= sa_ff;
               end else if (r > RW'(32767)) begin
                  value_ff <= 16'sh7fff;
               end else if (r < -RW'(32768)) begin
                  value_ff <= 16'sh8000;
               end else begin
                  value_ff <= r[SW-1:0];
               end
               done_ff <= 1'b1;
               state_ff <= I_IDLE;
            end
            default: state_ff <= I_IDLE;
         endcase
      end
   end

   assign rsp.done = done_ff;
   assign rsp.value = value_ff;

endmodule

/* hdl/variable_delay_interpolating.sv */
// Flow from an accepted req beat to its rsp beat: the ring update (S_OLD, S_NEW, S_WR),
//   the binary search (up to ten probes, each S_SRCH then S_CMP), the bracket reads (S_RA,
//   S_RB, S_CAPB), the multiply and the 18-step divide, and S_DONE to post the result.
// One item at a time, paced by the single RAM read port and the divide; the path is shorter
//   on an exact hit, equal bracket times or a saturated quotient.
// Reset (and every write to a known csr index) refills every ring slot, req_ready low meanwhile.
module variable_delay_interpolating #(
   parameter int DEPTH = dvdi_pkg::DEPTH_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  logic signed [dvdi_pkg::TIME_W-1:0] req_time_now,
   input  logic signed [dvdi_pkg::SAMPLE_W-1:0] req_sample_in,
   input  logic signed [dvdi_pkg::TIME_W-1:0] req_delay_req,
   output logic rsp_valid,
   input  logic rsp_ready,
   output logic signed [dvdi_pkg::SAMPLE_W-1:0] rsp_delayed_value,
   output logic rsp_underrun,
   input  logic csr_valid,
   output logic csr_ready,
   input  logic [dvdi_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [dvdi_pkg::CSR_DATA_W-1:0] csr_data
);

   localparam int PW = $clog2(DEPTH);
   localparam int TW = dvdi_pkg::TIME_W;
   localparam int SW = dvdi_pkg::SAMPLE_W;
   localparam int MW = dvdi_pkg::MAXD_W;
   localparam int WW = TW + SW;
   localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

   typedef enum logic [3:0] {
      S_IDLE, S_OLD, S_NEW, S_WR, S_SRCH, S_CMP, S_RA, S_RB, S_CAPB, S_CALC, S_DONE
   } state_type;

   state_type state_ff;
   logic [MW-1:0] max_ff, max_in;
   logic signed [SW-1:0] init_ff, init_in;
   logic fill_ff;
   logic [PW-1:0] fill_idx_ff;
   logic [TW-1:0] acc_ff;
   logic [PW-1:0] head_ff;
   logic signed [TW-1:0] t_ff, del_ff;
   logic signed [SW-1:0] s_ff;
   logic signed [TW:0] td_ff;
   logic under_ff;
   logic [PW-1:0] lo_ff, hi_ff, mid_ff;
   logic signed [TW-1:0] ta_ff;
   logic signed [SW-1:0] sa_ff;
   logic rsp_valid_ff, under_out_ff;
   logic signed [SW-1:0] value_out_ff, res_ff;
   dvdi_pkg::interp_req_type ireq_ff;
   dvdi_pkg::interp_rsp_type irsp;

   logic we;
   logic [PW-1:0] waddr, raddr;
   logic [WW-1:0] wdata, rdata;
   logic signed [TW-1:0] rd_time;
   logic signed [SW-1:0] rd_sample;
   logic [PW-1:0] newest, head_inc, mid, pos;
   logic [PW:0] lohi, pos_sum;
   logic signed [TW:0] maxd, del_c;
   logic csr_wr;

   dvdi_ram #(.WIDTH(WW), .DEPTH(DEPTH)) u_ram (
      .clock(clock), .we(we), .waddr(waddr), .wdata(wdata),
      .raddr(raddr), .rdata(rdata)
   );

   dvdi_interp u_interp (.clock(clock), .reset(reset), .req(ireq_ff), .rsp(irsp));

   assign rd_time = rdata[WW-1:SW];
   assign rd_sample = rdata[SW-1:0];

   // ring pointers
   assign newest = (head_ff == '0) ? LAST : head_ff - 1'b1;
   assign head_inc = (head_ff == LAST) ? '0 : head_ff + 1'b1;
   assign lohi = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign mid = lohi[PW:1];

   // position from oldest to RAM address
   always_comb begin
      case (state_ff)
         S_SRCH: pos = mid;
         S_RA: pos = lo_ff;
         default: pos = hi_ff;
      endcase
      pos_sum = {1'b0, pos} + {1'b0, head_ff};
      if (pos_sum >= (PW + 1)'(DEPTH)) begin
         pos_sum = pos_sum - (PW + 1)'(DEPTH);
      end
   end

   // delay clamp
   assign maxd = signed'({{(TW + 1 - MW){1'b0}}, max_ff});
   always_comb begin
      del_c = (TW + 1)'(del_ff);
      if (del_ff < 0) begin
         del_c = '0;
      end else if (del_c > maxd) begin
         del_c = maxd;
      end
   end

   // RAM ports: fill sweep or item update
   always_comb begin
      we = 1'b0;
      waddr = fill_idx_ff;
      wdata = {acc_ff, init_ff};
      if (fill_ff) begin
         we = 1'b1;
      end else if (state_ff == S_WR) begin
         we = 1'b1;
         waddr = (t_ff > rd_time) ? head_ff : newest;
         wdata = {t_ff, s_ff};
      end
      unique case (state_ff)
         S_OLD: raddr = head_ff;
         S_NEW: raddr = newest;
         default: raddr = pos_sum[PW-1:0];
      endcase
   end

   // configuration
   assign csr_ready = 1'b1;
   assign csr_wr = csr_valid && csr_ready &&
                   (csr_index == dvdi_pkg::CSR_MAX_DELAY ||
                    csr_index == dvdi_pkg::CSR_INIT_VALUE);
   assign max_in = (csr_index == dvdi_pkg::CSR_MAX_DELAY) ? csr_data : max_ff;
   assign init_in = (csr_index == dvdi_pkg::CSR_INIT_VALUE) ? csr_data[SW-1:0] : init_ff;

   assign req_ready = (state_ff == S_IDLE) && !fill_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_ff <= dvdi_pkg::MAX_DELAY_RST;
         init_ff <= dvdi_pkg::INIT_VALUE_RST;
         fill_ff <= 1'b1;
         fill_idx_ff <= LAST;
         acc_ff <= TW'(0) - TW'(dvdi_pkg::MAX_DELAY_RST);
         head_ff <= '0;
         state_ff <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         ireq_ff.start <= 1'b0;
      end else begin
         ireq_ff.start <= 1'b0;
         if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         // refill sweep from the newest slot down
         if (csr_wr) begin
            max_ff <= max_in;
            init_ff <= init_in;
            fill_ff <= 1'b1;
            fill_idx_ff <= LAST;
            acc_ff <= TW'(0) - TW'(max_in);
            head_ff <= '0;
         end else if (fill_ff) begin
            acc_ff <= acc_ff - TW'(max_ff);
            fill_idx_ff <= fill_idx_ff - 1'b1;
            if (fill_idx_ff == '0) begin
               fill_ff <= 1'b0;
            end
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid && req_ready) begin
                  t_ff <= req_time_now;
                  s_ff <= req_sample_in;
                  del_ff <= req_delay_req;
                  state_ff <= S_OLD;
               end
            end
            S_OLD: begin
               td_ff <= (TW + 1)'(t_ff) - del_c;
               state_ff <= S_NEW;
            end
            S_NEW: begin
               under_ff <= td_ff < (TW + 1)'(rd_time);
               state_ff <= S_WR;
            end
            S_WR: begin
               if (t_ff > rd_time) begin
                  head_ff <= head_inc;
               end
               lo_ff <= '0;
               hi_ff <= LAST;
               state_ff <= S_SRCH;
            end
            S_SRCH: begin
               mid_ff <= mid;
               state_ff <= (hi_ff - lo_ff > PW'(1)) ? S_CMP : S_RA;
            end
            S_CMP: begin
               if (td_ff < (TW + 1)'(rd_time)) begin
                  hi_ff <= mid_ff;
               end else if (td_ff > (TW + 1)'(rd_time)) begin
                  lo_ff <= mid_ff;
               end else begin
                  lo_ff <= mid_ff;
                  hi_ff <= mid_ff;
               end
               state_ff <= S_SRCH;
            end
            S_RA: state_ff <= S_RB;
            S_RB: begin
               ta_ff <= rd_time;
               sa_ff <= rd_sample;
               state_ff <= S_CAPB;
            end
            S_CAPB: begin
               ireq_ff.start <= 1'b1;
               ireq_ff.x <= dvdi_pkg::X_W'(td_ff) - dvdi_pkg::X_W'(ta_ff);
               ireq_ff.d <= dvdi_pkg::D_W'(rd_sample) - dvdi_pkg::D_W'(sa_ff);
               ireq_ff.dt <= dvdi_pkg::DT_W'(rd_time) - dvdi_pkg::DT_W'(ta_ff);
               ireq_ff.sa <= sa_ff;
               state_ff <= S_CALC;
            end
            S_CALC: begin
               if (irsp.done) begin
                  res_ff <= irsp.value;
                  state_ff <= S_DONE;
               end
            end
            S_DONE: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_ff <= 1'b1;
                  value_out_ff <= res_ff;
                  under_out_ff <= under_ff;
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_delayed_value = value_out_ff;
   assign rsp_underrun = under_out_ff;

`ifndef SYNTHESIS
   a_no_req_in_fill: assert property (@(posedge clock) disable iff (reset)
      fill_ff |-> !(req_valid && req_ready))
      else $error("req beat taken during ring refill");
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_DONE))
      else $error("rsp beat raised outside result stage");
   a_head_range: assert property (@(posedge clock) disable iff (reset)
      head_ff <= LAST)
      else $error("head pointer out of ring");
   a_search_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SRCH) |-> (lo_ff <= hi_ff))
      else $error("search bracket inverted");
`endif

endmodule

/* test/delay_line_checker.sv */
module delay_line_checker (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   input  logic req_ready,
   input  logic signed [dvdi_pkg::TIME_W-1:0] req_time_now,
   input  logic signed [dvdi_pkg::SAMPLE_W-1:0] req_sample_in,
   input  logic signed [dvdi_pkg::TIME_W-1:0] req_delay_req,
   input  logic rsp_valid,
   input  logic rsp_ready,
   input  logic signed [dvdi_pkg::SAMPLE_W-1:0] rsp_delayed_value,
   input  logic rsp_underrun,
   input  logic csr_valid,
   input  logic csr_ready,
   input  logic [dvdi_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [dvdi_pkg::CSR_DATA_W-1:0] csr_data,
   output int fail_count,
   output int pending
);
   localparam int RING = dvdi_pkg::DEPTH_DEF;
   localparam int TIME_W = dvdi_pkg::TIME_W;
   localparam int SAMPLE_W = dvdi_pkg::SAMPLE_W;
   localparam int MAXD_W = dvdi_pkg::MAXD_W;
   localparam longint QLIMIT = 64'sd1 << 40;

   typedef struct {
      logic signed [SAMPLE_W-1:0] value;
      logic under;
   } delayed_beat_type;

   logic [MAXD_W-1:0] max_delay;
   logic signed [SAMPLE_W-1:0] init_value;
   longint ring_time [RING];
   logic signed [SAMPLE_W-1:0] ring_sample [RING];
   int head;
   delayed_beat_type expected_q [$];

   assign pending = expected_q.size();

   // ring after reset or a register write: evenly spaced times ending at -max_delay
   function automatic void refill_ring();
      logic [63:0] base;
      logic [63:0] v;
      base = 64'd0 - 64'(max_delay) * 64'(RING);
      for (int i = 0; i < RING; i++) begin
         v = base + 64'(i) * 64'(max_delay);
         ring_time[i] = longint'($signed(v[TIME_W-1:0]));
         ring_sample[i] = init_value;
      end
      head = 0;
   endfunction

   // store the pair, search the bracket, interpolate
   function automatic delayed_beat_type interpolate_delayed(longint t,
                                                            logic signed [SAMPLE_W-1:0] s,
                                                            longint del);
      delayed_beat_type r;
      longint td, dt, x, d, res, q;
      int newest, lo, hi, mid, ia, ib;
      logic neg;
      logic [127:0] ax, adv, adt, prod;
      if (del < 0) del = 0;
      if (del > longint'({32'd0, max_delay})) del = longint'({32'd0, max_delay});
      td = t - del;
      newest = (head + RING - 1) % RING;
      r.under = td < ring_time[head];
      if (t > ring_time[newest]) begin
         ring_time[head] = t;
         ring_sample[head] = s;
         head = (head + 1) % RING;
      end else begin
         ring_time[newest] = t;
         ring_sample[newest] = s;
      end
      lo = 0;
      hi = RING - 1;
      while (hi - lo > 1) begin
         mid = (lo + hi) / 2;
         if (td < ring_time[(mid + head) % RING]) hi = mid;
         else if (td > ring_time[(mid + head) % RING]) lo = mid;
         else begin
            lo = mid;
            hi = mid;
         end
      end
      ia = (lo + head) % RING;
      ib = (hi + head) % RING;
      dt = ring_time[ib] - ring_time[ia];
      if (dt == 0) begin
         res = ring_sample[ia];
      end else begin
         x = td - ring_time[ia];
         d = longint'(ring_sample[ib]) - longint'(ring_sample[ia]);
         neg = ((x < 0) != (d < 0)) != (dt < 0);
         ax = 128'(x < 0 ? -x : x);
         adv = 128'(d < 0 ? -d : d);
         adt = 128'(dt < 0 ? -dt : dt);
         prod = (ax * adv) / adt;
         q = (prod > 128'(QLIMIT)) ? QLIMIT : longint'(prod[63:0]);
         res = longint'(ring_sample[ia]) + (neg ? -q : q);
      end
      if (res > 32767) res = 32767;
      if (res < -32768) res = -32768;
      r.value = res[SAMPLE_W-1:0];
      return r;
   endfunction

   // watch all three channels
   always @(posedge clock) begin
      delayed_beat_type got;
      delayed_beat_type want;
      if (reset) begin
         max_delay = dvdi_pkg::MAX_DELAY_RST;
         init_value = dvdi_pkg::INIT_VALUE_RST;
         refill_ring();
         expected_q.delete();
         fail_count = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == dvdi_pkg::CSR_MAX_DELAY) begin
               max_delay = csr_data;
               refill_ring();
            end else if (csr_index == dvdi_pkg::CSR_INIT_VALUE) begin
               init_value = csr_data[SAMPLE_W-1:0];
               refill_ring();
            end
         end
         if (req_valid && req_ready)
            expected_q.push_back(interpolate_delayed(longint'(req_time_now), req_sample_in,
                                                     longint'(req_delay_req)));
         if (rsp_valid && rsp_ready) begin
            got.value = rsp_delayed_value;
            got.under = rsp_underrun;
            if (expected_q.size() == 0) begin
               $error("unexpected rsp beat: delayed_value %0d underrun %0b",
                      got.value, got.under);
               fail_count++;
            end else begin
               want = expected_q.pop_front();
               if (got.value !== want.value) begin
                  $error("delayed_value: expected %0d, actual %0d", want.value, got.value);
                  fail_count++;
               end
               if (got.under !== want.under) begin
                  $error("underrun: expected %0b, actual %0b", want.under, got.under);
                  fail_count++;
               end
            end
         end
      end
   end
endmodule

/* test/tb.sv */
module tb;
   localparam int TIME_W = dvdi_pkg::TIME_W;
   localparam int SAMPLE_W = dvdi_pkg::SAMPLE_W;
   localparam int CSR_IDX_W = dvdi_pkg::CSR_IDX_W;
   localparam int CSR_DATA_W = dvdi_pkg::CSR_DATA_W;
   localparam int MAXD_W = dvdi_pkg::MAXD_W;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_ready;
   logic signed [TIME_W-1:0] req_time_now;
   logic signed [SAMPLE_W-1:0] req_sample_in;
   logic signed [TIME_W-1:0] req_delay_req;
   logic rsp_valid;
   logic rsp_ready;
   logic signed [SAMPLE_W-1:0] rsp_delayed_value;
   logic rsp_underrun;
   logic csr_valid;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0] csr_data;
   int fail_count;
   int pending;
   logic calm;
   logic [MAXD_W-1:0] cur_max_delay;
   longint cur_time;

   variable_delay_interpolating u_top (.*);

   delay_line_checker u_check (.*);

   initial begin
      clock = 0;
      forever #4 clock = ~clock;
   end

   initial begin
      #40000000;
      $display("Regression FAIL");
      $finish;
   end

   // result side back-pressure in bursts
   initial begin
      int n;
      rsp_ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!calm && $urandom_range(0, 5) == 0) begin
            n = $urandom_range(1, 10);
            rsp_ready <= 1'b0;
            repeat (n) @(posedge clock);
         end
         rsp_ready <= 1'b1;
      end
   end

   // one input beat, with an optional gap before it
   task automatic send_sample(longint t, logic [SAMPLE_W-1:0] s, longint d);
      if (!calm && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_time_now <= t[TIME_W-1:0];
      req_sample_in <= s;
      req_delay_req <= d[TIME_W-1:0];
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // drain, then write one register
   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      if (idx == dvdi_pkg::CSR_MAX_DELAY) cur_max_delay = val;
      cur_time = 0;
   endtask

   function automatic longint rand48();
      return longint'($signed({$urandom, $urandom} << 16)) >>> 16;
   endfunction

   // mostly rising time with random content, some noise
   task automatic run_phase(int count);
      longint md, step, d;
      md = longint'({32'd0, cur_max_delay});
      step = (md < 4) ? 4 : md / 2;
      if (step > 64'sd2000000000) step = 64'sd2000000000;
      for (int i = 0; i < count; i++) begin
         case ($urandom_range(0, 9))
            0: d = rand48();
            1: d = -longint'($urandom_range(0, 1000));
            2: d = md + $urandom_range(0, 1000);
            default: d = longint'({$urandom, $urandom} % 64'(md + 1));
         endcase
         case ($urandom_range(0, 19))
            0: send_sample(rand48(), SAMPLE_W'($urandom), d);
            1: send_sample(cur_time - $urandom_range(0, 50), SAMPLE_W'($urandom), d);
            default: begin
               cur_time += 1 + longint'({$urandom, $urandom} % 64'(step));
               send_sample(cur_time, SAMPLE_W'($urandom), d);
            end
         endcase
      end
   endtask

   initial begin
      longint maxt, mint;
      maxt = (64'sd1 << 47) - 1;
      mint = -(64'sd1 << 47);
      calm = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_time_now = '0;
      req_sample_in = '0;
      req_delay_req = '0;
      csr_valid = 1'b0;
      csr_index = dvdi_pkg::CSR_MAX_DELAY;
      csr_data = '0;
      cur_max_delay = dvdi_pkg::MAX_DELAY_RST;
      cur_time = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed: extremes, clamps, overwrite, exact hits, underrun
      send_sample(0, 16'sd1000, 0);
      send_sample(0, -16'sd1000, 5);
      send_sample(-1024, 16'sd32767, -7);
      send_sample(-1536, 16'sd0, 0);
      send_sample(-4000000, 16'sd5, 100);
      send_sample(100, 16'sh7fff, 50);
      send_sample(200, 16'sh8000, 150);
      send_sample(300, 16'sh7fff, 2000);
      send_sample(300, 16'sh8000, 0);
      send_sample(400, 16'sd1, maxt);
      send_sample(500, -16'sd1, mint);
      send_sample(maxt, 16'sh7fff, maxt);
      send_sample(maxt, 16'sh8000, 0);
      send_sample(mint, 16'sd77, 1);
      send_sample(mint, 16'sd3, mint);
      send_sample(0, 16'sd0, 1024);
      send_sample(-1, -16'sd5, 1023);

      write_csr(dvdi_pkg::CSR_MAX_DELAY, 32'd0);
      write_csr(dvdi_pkg::CSR_INIT_VALUE, 32'h0000_8000);
      send_sample(0, 16'sd10, 10);
      send_sample(5, 16'sd20, -3);
      run_phase(250);

      write_csr(dvdi_pkg::CSR_MAX_DELAY, 32'hffff_ffff);
      write_csr(dvdi_pkg::CSR_INIT_VALUE, 32'h0000_7fff);
      send_sample(0, 16'sh8000, maxt);
      send_sample(1, 16'sh7fff, 64'sd4294967295);
      run_phase(250);

      write_csr(dvdi_pkg::CSR_MAX_DELAY, 32'd1);
      write_csr(dvdi_pkg::CSR_INIT_VALUE, 32'd5);
      run_phase(250);

      write_csr(dvdi_pkg::CSR_MAX_DELAY, 32'd100);
      write_csr(dvdi_pkg::CSR_INIT_VALUE, 32'h0000_fb2e);
      run_phase(250);

      write_csr(dvdi_pkg::CSR_MAX_DELAY, 32'd1024);
      write_csr(dvdi_pkg::CSR_INIT_VALUE, 32'd0);
      run_phase(150);
      calm = 1'b1;
      run_phase(150);
      req_valid <= 1'b0;

      // drain and settle
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (fail_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end
endmodule

/* variable_delay_interpolating.f */
hdl/dvdi_pkg.sv
hdl/dvdi_ram.sv
hdl/dvdi_interp.sv
hdl/variable_delay_interpolating.sv
test/delay_line_checker.sv
test/tb.sv
